### hw/rtl/sds_pkg.sv
// Shared types, constants and helpers of the scatter direction sampler.
package sds_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int SQRT_STEPS    = 31;
    localparam int STEP_STAGES   = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
    localparam int DIV_BITS      = 33;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);

    localparam logic signed [31:0] ONE_Q30     = 32'sh4000_0000;
    localparam logic [30:0]        HALF_PI_Q30 = 31'd1686629713;
    localparam logic signed [33:0] CORDIC_K    = 34'sd652032874;

    localparam logic [29:0] ATAN_TAB [32] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
        30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
        30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
        30'd262143,    30'd131071,    30'd65535,     30'd32767,
        30'd16383,     30'd8191,      30'd4095,      30'd2047,
        30'd1023,      30'd511,       30'd255,       30'd127,
        30'd63,        30'd31,        30'd15,        30'd7,
        30'd3,         30'd1,         30'd0,         30'd0
    };

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_AXIS_X    = 3'd1;
    localparam logic [2:0] REG_AXIS_Y    = 3'd2;
    localparam logic [2:0] REG_AXIS_Z    = 3'd3;
    localparam logic [2:0] REG_AXIS_SINE = 3'd4;

    localparam logic MODE_ISO  = 1'b0;
    localparam logic MODE_AXIS = 1'b1;

    typedef logic signed [31:0] q30_t;

    typedef struct packed {
        logic        mode;
        q30_t        axis_x;
        q30_t        axis_y;
        q30_t        axis_z;
        logic [30:0] axis_sine;
    } cfg_t;

    // classified request handed from front to back
    typedef struct packed {
        logic [1:0]  quad;
        logic [30:0] theta;
        q30_t        mu;
    } item_t;

    function automatic q30_t sat_q30(input logic signed [67:0] v);
        if (v > 68'sd1073741824) begin
            return ONE_Q30;
        end
        if (v < -68'sd1073741824) begin
            return -ONE_Q30;
        end
        return v[31:0];
    endfunction

endpackage

### hw/rtl/sds_front.sv
// Front stage: takes input requests, derives azimuth angle and polar cosine.
module sds_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  sds_pkg::cfg_t cfg,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [95:0]   s_tdata,   // uniform_a, uniform_b, cosine_in
    output logic          push,
    output sds_pkg::item_t push_item,
    input  logic          q_ready
);
    import sds_pkg::*;

    logic         valid_reg, valid_next;
    item_t        item_reg, item_next;
    logic [60:0]  theta_prod;
    logic signed [32:0] mu_iso;
    q30_t         cos_in;

    assign s_tready  = !valid_reg || q_ready;
    assign push      = valid_reg;
    assign push_item = item_reg;

    always_comb begin
        theta_prod = 61'(s_tdata[61:32]) * 61'(HALF_PI_Q30);
        mu_iso     = $signed({2'b00, s_tdata[31:1]}) - 33'sd1073741824;
        cos_in     = s_tdata[95:64];
        item_next.quad  = s_tdata[63:62];
        item_next.theta = theta_prod[60:30];
        item_next.mu    = (cfg.mode == MODE_AXIS) ? sat_q30(68'(cos_in)) : mu_iso[31:0];
        valid_next      = s_tready ? s_tvalid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
    end

endmodule

### hw/rtl/sds_queue.sv
// Short request queue between the front and back parts.
module sds_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    input  sds_pkg::item_t in_item,
    output logic           in_ready,
    output logic           out_valid,
    output sds_pkg::item_t out_item,
    input  logic           out_pop
);
    import sds_pkg::*;

    item_t                  mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg, count_next;
    logic                   push_ok, pop_ok;

    assign in_ready  = count_reg != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push_ok   = in_valid && in_ready;
    assign pop_ok    = out_pop && out_valid;

    always_comb begin
        wr_ptr_next = push_ok ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_ok ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok && !pop_ok) begin
            count_next = count_reg + 1'b1;
        end else if (pop_ok && !push_ok) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_ok) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QUEUE_PTR_W + 1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

### hw/rtl/sds_back.sv
// Back pipeline: CORDIC and square root, axis rotation products, divider, saturation.
module sds_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  sds_pkg::cfg_t  cfg,
    input  logic           q_valid,
    input  sds_pkg::item_t q_item,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [95:0]    m_tdata,   // dir_x, dir_y, dir_z
    output logic           m_tuser    // axis_fault
);
    import sds_pkg::*;

    localparam int IDX_TRIG = STEP_STAGES + 1;
    localparam int IDX_D0   = STEP_STAGES + 6;
    localparam int NV       = STEP_STAGES + 7 + DIV_BITS;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic [1:0]         quad;
        logic signed [33:0] cx;
        logic signed [33:0] cy;
        logic signed [32:0] cz;
        q30_t               mu;
        logic [60:0]        rem;
        logic [61:0]        root;
    } step_t;

    typedef struct packed {
        logic [62:0] mag;
        logic        neg;
        logic        ovf;
        logic [32:0] quot;
    } dlane_t;

    typedef struct packed {
        q30_t               mu;
        q30_t               css;
        q30_t               sns;
        logic signed [33:0] axmu;
        logic signed [33:0] aymu;
        logic signed [33:0] azmu;
        logic signed [34:0] zr;
    } carry_t;

    function automatic q30_t apply_quot(input dlane_t d, input logic signed [33:0] base);
        logic signed [33:0] qs;
        logic signed [67:0] sum;
        qs  = $signed({1'b0, d.quot});
        sum = 68'(base) + (d.neg ? -68'(qs) : 68'(qs));
        if (d.ovf) begin
            return d.neg ? -ONE_Q30 : ONE_Q30;
        end
        return sat_q30(sum);
    endfunction

    logic          adv;
    logic [NV-1:0] pipe_valid_reg, pipe_valid_next;
    logic          m_valid_reg, m_valid_next;

    assign adv   = !m_valid_reg || m_tready;
    assign q_pop = adv;

    always_comb begin
        pipe_valid_next = {pipe_valid_reg[NV-2:0], q_valid};
        m_valid_next    = pipe_valid_reg[NV-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_valid_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else if (adv) begin
            pipe_valid_reg <= pipe_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // ---------------- prep: CORDIC seed and sqrt radicand
    step_t              st_reg [STEP_STAGES+1];
    logic signed [63:0] mu_sq;

    assign mu_sq = q_item.mu * q_item.mu;

    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg[0] <= '{quad: q_item.quad, cx: CORDIC_K, cy: '0,
                           cz: $signed({2'b00, q_item.theta}), mu: q_item.mu,
                           rem: (61'(1) << 60) - mu_sq[60:0], root: '0};
        end
    end

    // ---------------- rotation and root steps, one digit per stage
    for (genvar k = 0; k < STEP_STAGES; k++) begin : g_step
        logic signed [33:0] rx, ry;
        logic signed [32:0] rz;
        logic [60:0]        srem;
        logic [61:0]        sroot;

        if (k < CORDIC_STAGES) begin : g_rot
            always_comb begin
                if (!st_reg[k].cz[32]) begin
                    rx = st_reg[k].cx - (st_reg[k].cy >>> k);
                    ry = st_reg[k].cy + (st_reg[k].cx >>> k);
                    rz = st_reg[k].cz - $signed({3'b000, ATAN_TAB[k]});
                end else begin
                    rx = st_reg[k].cx + (st_reg[k].cy >>> k);
                    ry = st_reg[k].cy - (st_reg[k].cx >>> k);
                    rz = st_reg[k].cz + $signed({3'b000, ATAN_TAB[k]});
                end
            end
        end else begin : g_rot_pass
            assign rx = st_reg[k].cx;
            assign ry = st_reg[k].cy;
            assign rz = st_reg[k].cz;
        end

        if (k < SQRT_STEPS) begin : g_sq
            localparam logic [61:0] SqBit = 62'(1) << (60 - 2 * k);
            logic [61:0] trial;
            always_comb begin
                trial = st_reg[k].root + SqBit;
                if ({1'b0, st_reg[k].rem} >= trial) begin
                    srem  = 61'({1'b0, st_reg[k].rem} - trial);
                    sroot = (st_reg[k].root >> 1) + SqBit;
                end else begin
                    srem  = st_reg[k].rem;
                    sroot = st_reg[k].root >> 1;
                end
            end
        end else begin : g_sq_pass
            assign srem  = st_reg[k].rem;
            assign sroot = st_reg[k].root;
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                st_reg[k+1] <= '{quad: st_reg[k].quad, cx: rx, cy: ry, cz: rz,
                                 mu: st_reg[k].mu, rem: srem, root: sroot};
            end
        end
    end

    // ---------------- clamp and quadrant fold
    step_t       st_last;
    q30_t        c_sat, s_sat, cs_next, sn_next;
    q30_t        tg_cs_reg, tg_sn_reg, tg_mu_reg;
    logic [30:0] tg_s_reg;

    assign st_last = st_reg[STEP_STAGES];

    always_comb begin
        c_sat = sat_q30(68'(st_last.cx));
        s_sat = sat_q30(68'(st_last.cy));
        unique case (st_last.quad)
            QUAD_0: begin cs_next = c_sat;  sn_next = s_sat;  end
            QUAD_1: begin cs_next = -s_sat; sn_next = c_sat;  end
            QUAD_2: begin cs_next = -c_sat; sn_next = -s_sat; end
            QUAD_3: begin cs_next = s_sat;  sn_next = -c_sat; end
            default: begin cs_next = c_sat; sn_next = s_sat;  end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tg_cs_reg <= cs_next;
            tg_sn_reg <= sn_next;
            tg_mu_reg <= st_last.mu;
            tg_s_reg  <= st_last.root[30:0];
        end
    end

    // ---------------- M1: first-level products
    q30_t               tg_ss, st_s;
    logic signed [63:0] pr_axaz, pr_ayaz, pr_aysn, pr_axsn;
    logic signed [63:0] pr_axmu, pr_aymu, pr_azmu, pr_css, pr_sns;
    logic signed [33:0] m1_axaz_reg, m1_ayaz_reg, m1_aysn_reg, m1_axsn_reg;
    logic signed [33:0] m1_axmu_reg, m1_aymu_reg, m1_azmu_reg;
    q30_t               m1_css_reg, m1_sns_reg, m1_cs_reg, m1_mu_reg;
    logic [30:0]        m1_s_reg;

    assign tg_ss = $signed({1'b0, tg_s_reg});
    assign st_s  = $signed({1'b0, cfg.axis_sine});

    always_comb begin
        pr_axaz = cfg.axis_x * cfg.axis_z;
        pr_ayaz = cfg.axis_y * cfg.axis_z;
        pr_aysn = cfg.axis_y * tg_sn_reg;
        pr_axsn = cfg.axis_x * tg_sn_reg;
        pr_axmu = cfg.axis_x * tg_mu_reg;
        pr_aymu = cfg.axis_y * tg_mu_reg;
        pr_azmu = cfg.axis_z * tg_mu_reg;
        pr_css  = tg_cs_reg * tg_ss;
        pr_sns  = tg_sn_reg * tg_ss;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m1_axaz_reg <= pr_axaz[63:30];
            m1_ayaz_reg <= pr_ayaz[63:30];
            m1_aysn_reg <= pr_aysn[63:30];
            m1_axsn_reg <= pr_axsn[63:30];
            m1_axmu_reg <= pr_axmu[63:30];
            m1_aymu_reg <= pr_aymu[63:30];
            m1_azmu_reg <= pr_azmu[63:30];
            m1_css_reg  <= pr_css[61:30];
            m1_sns_reg  <= pr_sns[61:30];
            m1_cs_reg   <= tg_cs_reg;
            m1_mu_reg   <= tg_mu_reg;
            m1_s_reg    <= tg_s_reg;
        end
    end

    // ---------------- M2: second-level products
    logic signed [65:0] pr_tx, pr_ty;
    logic signed [63:0] pr_zt;
    logic signed [33:0] m2_tx_reg, m2_ty_reg, m2_zt_reg;
    logic signed [33:0] m2_aysn_reg, m2_axsn_reg, m2_axmu_reg, m2_aymu_reg, m2_azmu_reg;
    q30_t               m2_css_reg, m2_sns_reg, m2_mu_reg;
    logic [30:0]        m2_s_reg;

    always_comb begin
        pr_tx = m1_axaz_reg * m1_cs_reg;
        pr_ty = m1_ayaz_reg * m1_cs_reg;
        pr_zt = m1_css_reg * st_s;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m2_tx_reg   <= pr_tx[63:30];
            m2_ty_reg   <= pr_ty[63:30];
            m2_zt_reg   <= pr_zt[63:30];
            m2_aysn_reg <= m1_aysn_reg;
            m2_axsn_reg <= m1_axsn_reg;
            m2_axmu_reg <= m1_axmu_reg;
            m2_aymu_reg <= m1_aymu_reg;
            m2_azmu_reg <= m1_azmu_reg;
            m2_css_reg  <= m1_css_reg;
            m2_sns_reg  <= m1_sns_reg;
            m2_mu_reg   <= m1_mu_reg;
            m2_s_reg    <= m1_s_reg;
        end
    end

    // ---------------- M3: numerator sums
    logic signed [34:0] m3_bx_reg, m3_by_reg;
    logic [30:0]        m3_s_reg;
    carry_t             m3_cr_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            m3_bx_reg <= 35'(m2_tx_reg) - 35'(m2_aysn_reg);
            m3_by_reg <= 35'(m2_ty_reg) + 35'(m2_axsn_reg);
            m3_s_reg  <= m2_s_reg;
            m3_cr_reg <= '{mu: m2_mu_reg, css: m2_css_reg, sns: m2_sns_reg,
                           axmu: m2_axmu_reg, aymu: m2_aymu_reg, azmu: m2_azmu_reg,
                           zr: 35'(m2_azmu_reg) - 35'(m2_zt_reg)};
        end
    end

    // ---------------- M4: numerator times root
    logic signed [66:0] pr_nx, pr_ny;
    logic signed [63:0] m4_nx_reg, m4_ny_reg;
    carry_t             m4_cr_reg;

    always_comb begin
        pr_nx = m3_bx_reg * $signed({1'b0, m3_s_reg});
        pr_ny = m3_by_reg * $signed({1'b0, m3_s_reg});
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m4_nx_reg <= pr_nx[63:0];
            m4_ny_reg <= pr_ny[63:0];
            m4_cr_reg <= m3_cr_reg;
        end
    end

    // ---------------- divider: sign/magnitude, then one quotient bit per stage
    dlane_t dx_reg [DIV_BITS+1];
    dlane_t dy_reg [DIV_BITS+1];
    carry_t cr_reg [DIV_BITS+1];
    logic [63:0] nx_neg, ny_neg;

    assign nx_neg = -m4_nx_reg;
    assign ny_neg = -m4_ny_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            dx_reg[0] <= '{mag: m4_nx_reg[63] ? nx_neg[62:0] : m4_nx_reg[62:0],
                           neg: m4_nx_reg[63], ovf: 1'b0, quot: '0};
            dy_reg[0] <= '{mag: m4_ny_reg[63] ? ny_neg[62:0] : m4_ny_reg[62:0],
                           neg: m4_ny_reg[63], ovf: 1'b0, quot: '0};
            cr_reg[0] <= m4_cr_reg;
        end
    end

    for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
        localparam int Sh = DIV_BITS - 1 - k;
        logic [62:0] den;
        dlane_t      nxl, nyl;

        assign den = 63'(cfg.axis_sine) << Sh;

        always_comb begin
            nxl = dx_reg[k];
            nyl = dy_reg[k];
            if (k == 0) begin
                // quotient too wide to matter: output saturates on its sign
                nxl.ovf = {1'b0, dx_reg[k].mag} >= (64'(cfg.axis_sine) << DIV_BITS);
                nyl.ovf = {1'b0, dy_reg[k].mag} >= (64'(cfg.axis_sine) << DIV_BITS);
            end
            if (dx_reg[k].mag >= den) begin
                nxl.mag  = dx_reg[k].mag - den;
                nxl.quot = {dx_reg[k].quot[31:0], 1'b1};
            end else begin
                nxl.quot = {dx_reg[k].quot[31:0], 1'b0};
            end
            if (dy_reg[k].mag >= den) begin
                nyl.mag  = dy_reg[k].mag - den;
                nyl.quot = {dy_reg[k].quot[31:0], 1'b1};
            end else begin
                nyl.quot = {dy_reg[k].quot[31:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dx_reg[k+1] <= nxl;
                dy_reg[k+1] <= nyl;
                cr_reg[k+1] <= cr_reg[k];
            end
        end
    end

    // ---------------- final select and saturation
    carry_t cr_last;
    q30_t   ox_next, oy_next, oz_next;
    logic   fault_next;
    q30_t   dir_x_reg, dir_y_reg, dir_z_reg;
    logic   fault_reg;

    assign cr_last = cr_reg[DIV_BITS];

    always_comb begin
        fault_next = 1'b0;
        if (cfg.mode == MODE_ISO) begin
            ox_next = sat_q30(68'(cr_last.mu));
            oy_next = sat_q30(68'(cr_last.css));
            oz_next = sat_q30(68'(cr_last.sns));
        end else if (cfg.axis_sine == '0) begin
            ox_next    = sat_q30(68'(cr_last.axmu));
            oy_next    = sat_q30(68'(cr_last.aymu));
            oz_next    = sat_q30(68'(cr_last.azmu));
            fault_next = 1'b1;
        end else begin
            ox_next = apply_quot(dx_reg[DIV_BITS], cr_last.axmu);
            oy_next = apply_quot(dy_reg[DIV_BITS], cr_last.aymu);
            oz_next = sat_q30(68'(cr_last.zr));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dir_x_reg <= ox_next;
            dir_y_reg <= oy_next;
            dir_z_reg <= oz_next;
            fault_reg <= fault_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {dir_z_reg, dir_y_reg, dir_x_reg};
    assign m_tuser  = fault_reg;

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(pipe_valid_reg))
        else $error("pipeline advanced while output stalled");

    a_root_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_valid_reg[STEP_STAGES] |-> st_last.root <= 62'(1) << 30)
        else $error("square root above one");

    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (dir_x_reg <= ONE_Q30 && dir_x_reg >= -ONE_Q30 &&
                         dir_y_reg <= ONE_Q30 && dir_y_reg >= -ONE_Q30 &&
                         dir_z_reg <= ONE_Q30 && dir_z_reg >= -ONE_Q30))
        else $error("unsaturated direction component");

    a_trig_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_valid_reg[IDX_TRIG] |-> (tg_cs_reg <= ONE_Q30 && tg_cs_reg >= -ONE_Q30))
        else $error("cosine out of range");

    a_div_seed: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_valid_reg[IDX_D0] |-> dx_reg[0].quot == '0)
        else $error("divider seed not cleared");

endmodule

### hw/rtl/scatter_direction_sampler_top.sv
// Top level: APB register bank, front classifier, request queue and back pipeline.
//
// Draws one unit direction vector (signed Q1.30) per input request.
// s_ channel: s_tdata = {cosine_in, uniform_b, uniform_a}, 96 bits.
// m_ channel: m_tdata = {dir_z, dir_y, dir_x}, m_tuser = axis_fault.
// APB: mode, axis_x, axis_y, axis_z, axis_sine at byte addresses 0x0..0x10;
// write only while no request is in flight.
// Throughput: one request per cycle while m_tready does not stall the output; the back pipeline is fully staged.
// Path from input acceptance to m_tvalid: front register, queue slot,
// radicand stage, 31 CORDIC/root stages, quadrant stage, four product
// stages, sign stage, 33 restoring divider stages, output register.
// The root digit-by-digit stages and the divider stages make up most of that path.
// Reset (aresetn low, synchronous) empties all stages and the queue and sets
// the registers to isotropic mode with axis (0, 0, 1).
// When m_tready is low with a result waiting, the back pipeline holds; the
// four-entry queue and the front register keep s_tready high until they fill.
module scatter_direction_sampler_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // uniform_a, uniform_b, cosine_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // dir_x, dir_y, dir_z
    output logic        m_tuser,   // axis_fault
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sds_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  wr_en;
    logic  push, q_ready, q_valid, q_pop;
    item_t push_item, q_item;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (paddr[4:2])
                REG_MODE:      cfg_next.mode      = pwdata[0];
                REG_AXIS_X:    cfg_next.axis_x    = pwdata;
                REG_AXIS_Y:    cfg_next.axis_y    = pwdata;
                REG_AXIS_Z:    cfg_next.axis_z    = pwdata;
                REG_AXIS_SINE: cfg_next.axis_sine = pwdata[30:0];
                default:       cfg_next           = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{mode: MODE_ISO, axis_x: '0, axis_y: '0,
                         axis_z: ONE_Q30, axis_sine: '0};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_MODE:      prdata = {31'b0, cfg_reg.mode};
            REG_AXIS_X:    prdata = cfg_reg.axis_x;
            REG_AXIS_Y:    prdata = cfg_reg.axis_y;
            REG_AXIS_Z:    prdata = cfg_reg.axis_z;
            REG_AXIS_SINE: prdata = {1'b0, cfg_reg.axis_sine};
            default:       prdata = '0;
        endcase
    end

    sds_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push      (push),
        .push_item (push_item),
        .q_ready   (q_ready)
    );

    sds_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push),
        .in_item   (push_item),
        .in_ready  (q_ready),
        .out_valid (q_valid),
        .out_item  (q_item),
        .out_pop   (q_pop)
    );

    sds_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
